FILE: rtl/obo_pkg.sv
// Shared types and constants for the oriented box overlap pipeline.
`default_nettype none

package obo_pkg;

    // Q1.14 sine/cosine, signed, covers -1.0 .. +1.0
    localparam int TRIG_W = 16;
    // unsigned quarter-wave ROM entry, 0 .. 16384
    localparam int ROM_W = 15;
    localparam logic signed [TRIG_W-1:0] ONE_Q14 = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] ZERO_Q14 = 16'sd0;

    // quadrant codes of the angle
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // stage advance strobes handed to the trig unit
    typedef struct packed {
        logic s1;
        logic s2;
    } obo_en_t;

endpackage

`default_nettype wire

FILE: rtl/oriented_box_overlap_sat.sv
// Top level: streaming overlap test of two oriented rectangles (separating axes).
//
// Takes one box pair per transaction and returns one overlap flag per pair;
// a new pair may enter every cycle while the output side is not stalled. The
// seven register stages are: ROM read of quarter-wave sine, quadrant fold,
// axis products, projection sums and absolute values, extent products, extent
// sums, final compare. Each stage holds its own valid bit and only stalls when
// everything downstream of it is full, so the input keeps taking pairs while a
// result waits on a stalled output as long as any stage below is empty.
// Overlap is exact: on each of the six axes |center distance| is compared with
// the sum of the two half-extents, touching counts as overlap. No state
// survives a transaction.
`default_nettype none

module oriented_box_overlap_sat #(
    parameter int COORD_BITS = 16,
    parameter int ANGLE_BITS = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // from bit 0: center_a_x, center_a_y, width_a, height_a, angle_a,
    // center_b_x, center_b_y, width_b, height_b, angle_b, zero fill
    input  wire logic [((2*(4*COORD_BITS-2+ANGLE_BITS)+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // bit 0: overlap, bits 7:1 zero
    output logic [7:0] m_tdata
);

    localparam int CB    = COORD_BITS;
    localparam int SB    = COORD_BITS - 1;
    localparam int TW    = obo_pkg::TRIG_W;
    localparam int BOX_W = 4*CB - 2 + ANGLE_BITS;
    localparam int NST   = 7;
    localparam int NAX   = 6;
    localparam int PW    = 2*TW;          // trig by trig product
    localparam int MW    = PW - 2;        // |alpha|, |beta| magnitude
    localparam int DW    = CB + 1;        // center difference
    localparam int DPW   = DW + TW;       // axis times difference
    localparam int DMW   = DPW;           // |projected distance|
    localparam int EW    = MW + SB;       // one extent term
    localparam int ESW   = EW + 2;        // four extent terms
    localparam int CW    = DMW + 15;      // distance scaled to corner units

    // field offsets inside s_tdata
    localparam int O_AX = 0;
    localparam int O_AY = O_AX + CB;
    localparam int O_AW = O_AY + CB;
    localparam int O_AH = O_AW + SB;
    localparam int O_AA = O_AH + SB;
    localparam int O_B  = BOX_W;

    // stage control
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int i = NST-2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        for (int i = 0; i < NST; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = (i == 0) ? s_tvalid : vld_reg[(i == 0) ? 0 : i-1];
            end
            else
            begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];

    // stage 1: capture geometry, ROM read inside trig units
    obo_pkg::obo_en_t trig_en;
    assign trig_en.s1 = en[0];
    assign trig_en.s2 = en[1];

    logic signed [TW-1:0] sin_a;
    logic signed [TW-1:0] cos_a;
    logic signed [TW-1:0] sin_b;
    logic signed [TW-1:0] cos_b;

    obo_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_a (
        .clk     (clk),
        .en      (trig_en),
        .angle   (s_tdata[O_AA +: ANGLE_BITS]),
        .sin_val (sin_a),
        .cos_val (cos_a)
    );

    obo_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_b (
        .clk     (clk),
        .en      (trig_en),
        .angle   (s_tdata[O_B + O_AA +: ANGLE_BITS]),
        .sin_val (sin_b),
        .cos_val (cos_b)
    );

    logic signed [CB-1:0] cax_reg;
    logic signed [CB-1:0] cay_reg;
    logic signed [CB-1:0] cbx_reg;
    logic signed [CB-1:0] cby_reg;
    logic [SB-1:0] w1_reg [2];
    logic [SB-1:0] h1_reg [2];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cax_reg   <= $signed(s_tdata[O_AX +: CB]);
            cay_reg   <= $signed(s_tdata[O_AY +: CB]);
            cbx_reg   <= $signed(s_tdata[O_B + O_AX +: CB]);
            cby_reg   <= $signed(s_tdata[O_B + O_AY +: CB]);
            w1_reg[0] <= s_tdata[O_AW +: SB];
            h1_reg[0] <= s_tdata[O_AH +: SB];
            w1_reg[1] <= s_tdata[O_B + O_AW +: SB];
            h1_reg[1] <= s_tdata[O_B + O_AH +: SB];
        end
    end

    // stage 2: center difference (trig fold runs alongside)
    logic signed [DW-1:0] dcx_reg;
    logic signed [DW-1:0] dcy_reg;
    logic [SB-1:0] w2_reg [2];
    logic [SB-1:0] h2_reg [2];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dcx_reg <= DW'(cax_reg) - DW'(cbx_reg);
            dcy_reg <= DW'(cay_reg) - DW'(cby_reg);
            w2_reg  <= w1_reg;
            h2_reg  <= h1_reg;
        end
    end

    // stage 3: axis products
    logic signed [TW-1:0] ux [NAX];
    logic signed [TW-1:0] uy [NAX];
    logic signed [TW-1:0] bs [2];
    logic signed [TW-1:0] bc [2];

    always_comb
    begin
        ux[0] = obo_pkg::ONE_Q14;  uy[0] = obo_pkg::ZERO_Q14;
        ux[1] = obo_pkg::ZERO_Q14; uy[1] = obo_pkg::ONE_Q14;
        ux[2] = cos_a;             uy[2] = sin_a;
        ux[3] = -sin_a;            uy[3] = cos_a;
        ux[4] = cos_b;             uy[4] = sin_b;
        ux[5] = -sin_b;            uy[5] = cos_b;
        bs[0] = sin_a; bc[0] = cos_a;
        bs[1] = sin_b; bc[1] = cos_b;
    end

    logic signed [PW-1:0] pa_reg [NAX][2];
    logic signed [PW-1:0] pb_reg [NAX][2];
    logic signed [PW-1:0] pc_reg [NAX][2];
    logic signed [PW-1:0] pd_reg [NAX][2];
    logic signed [DPW-1:0] pe_reg [NAX];
    logic signed [DPW-1:0] pf_reg [NAX];
    logic [SB-1:0] w3_reg [2];
    logic [SB-1:0] h3_reg [2];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < NAX; i++)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    pa_reg[i][k] <= ux[i] * bc[k];
                    pb_reg[i][k] <= uy[i] * bs[k];
                    pc_reg[i][k] <= uy[i] * bc[k];
                    pd_reg[i][k] <= ux[i] * bs[k];
                end
                pe_reg[i] <= ux[i] * dcx_reg;
                pf_reg[i] <= uy[i] * dcy_reg;
            end
            w3_reg <= w2_reg;
            h3_reg <= h2_reg;
        end
    end

    // stage 4: corner-offset coefficients and distance, as magnitudes
    logic signed [PW-1:0]  alpha_s [NAX][2];
    logic signed [PW-1:0]  beta_s  [NAX][2];
    logic signed [DPW:0]   dist_s  [NAX];
    logic [MW-1:0]  alpha_reg [NAX][2];
    logic [MW-1:0]  beta_reg  [NAX][2];
    logic [DMW-1:0] dmag4_reg [NAX];
    logic [SB-1:0]  w4_reg [2];
    logic [SB-1:0]  h4_reg [2];

    always_comb
    begin
        for (int i = 0; i < NAX; i++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                alpha_s[i][k] = pa_reg[i][k] + pb_reg[i][k];
                beta_s[i][k]  = pc_reg[i][k] - pd_reg[i][k];
            end
            dist_s[i] = (DPW+1)'(pe_reg[i]) + (DPW+1)'(pf_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < NAX; i++)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    alpha_reg[i][k] <= alpha_s[i][k][PW-1] ?
                                       MW'(-alpha_s[i][k]) : MW'(alpha_s[i][k]);
                    beta_reg[i][k]  <= beta_s[i][k][PW-1] ?
                                       MW'(-beta_s[i][k]) : MW'(beta_s[i][k]);
                end
                dmag4_reg[i] <= dist_s[i][DPW] ? DMW'(-dist_s[i]) : DMW'(dist_s[i]);
            end
            w4_reg <= w3_reg;
            h4_reg <= h3_reg;
        end
    end

    // stage 5: half-extent terms
    logic [EW-1:0]  ew_reg [NAX][2];
    logic [EW-1:0]  eh_reg [NAX][2];
    logic [DMW-1:0] dmag5_reg [NAX];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < NAX; i++)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    ew_reg[i][k] <= EW'(alpha_reg[i][k]) * EW'(w4_reg[k]);
                    eh_reg[i][k] <= EW'(beta_reg[i][k]) * EW'(h4_reg[k]);
                end
            end
            dmag5_reg <= dmag4_reg;
        end
    end

    // stage 6: sum of both boxes' half-extents
    logic [ESW-1:0] esum_reg [NAX];
    logic [DMW-1:0] dmag6_reg [NAX];

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int i = 0; i < NAX; i++)
            begin
                esum_reg[i] <= ESW'(ew_reg[i][0]) + ESW'(eh_reg[i][0])
                             + ESW'(ew_reg[i][1]) + ESW'(eh_reg[i][1]);
            end
            dmag6_reg <= dmag5_reg;
        end
    end

    // stage 7: per-axis compare; distance is in center units, scale by 2^15
    logic overlap_next;
    logic overlap_reg;

    always_comb
    begin
        overlap_next = 1'b1;
        for (int i = 0; i < NAX; i++)
        begin
            if ({dmag6_reg[i], 15'b0} > CW'(esum_reg[i]))
            begin
                overlap_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            overlap_reg <= overlap_next;
        end
    end

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {7'b0, overlap_reg};

endmodule

`default_nettype wire

FILE: rtl/obo_trig.sv
// Two-stage sine/cosine unit: quarter-wave ROM read, then quadrant fold.
`default_nettype none

module obo_trig #(
    parameter int ANGLE_BITS = 12
) (
    input  wire logic                                clk,
    input  wire obo_pkg::obo_en_t                    en,
    input  wire logic [ANGLE_BITS-1:0]               angle,
    output logic signed [obo_pkg::TRIG_W-1:0]        sin_val,
    output logic signed [obo_pkg::TRIG_W-1:0]        cos_val
);

    localparam int QS      = ANGLE_BITS - 2;
    localparam int QUARTER = 1 << QS;
    localparam int ADDR_W  = QS + 1;
    localparam int RW      = obo_pkg::ROM_W;

    // quarter sine, Taylor series in Q2.30, rounded to Q1.14
    function automatic logic [RW-1:0] qsin(input logic [63:0] t);
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] v;
        r    = (t * 64'd1686629713 + 64'(QUARTER / 2)) >> QS;
        r2   = (r * r) >> 30;
        term = r;
        sum  = $signed(r);
        term = ((term * r2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * r2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * r2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * r2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * r2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * r2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        v = ($unsigned(sum) + 64'd32768) >> 16;
        if (v > 64'd16384)
        begin
            v = 64'd16384;
        end
        return RW'(v);
    endfunction

    function automatic logic [(QUARTER+1)*RW-1:0] build_rom();
        logic [(QUARTER+1)*RW-1:0] rv;
        rv = '0;
        for (int i = 0; i <= QUARTER; i++)
        begin
            rv[i*RW +: RW] = qsin(64'(i));
        end
        return rv;
    endfunction

    localparam logic [(QUARTER+1)*RW-1:0] ROM = build_rom();

    logic [ADDR_W-1:0] addr_p;
    logic [ADDR_W-1:0] addr_m;
    logic [RW-1:0]     p_reg;
    logic [RW-1:0]     m_reg;
    logic [1:0]        quad_reg;
    logic signed [obo_pkg::TRIG_W-1:0] p_s;
    logic signed [obo_pkg::TRIG_W-1:0] m_s;
    logic signed [obo_pkg::TRIG_W-1:0] sin_next;
    logic signed [obo_pkg::TRIG_W-1:0] cos_next;
    logic signed [obo_pkg::TRIG_W-1:0] sin_reg;
    logic signed [obo_pkg::TRIG_W-1:0] cos_reg;

    assign addr_p = {1'b0, angle[QS-1:0]};
    assign addr_m = ADDR_W'(QUARTER) - addr_p;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            p_reg    <= ROM[addr_p*RW +: RW];
            m_reg    <= ROM[addr_m*RW +: RW];
            quad_reg <= angle[ANGLE_BITS-1 -: 2];
        end
    end

    assign p_s = $signed({1'b0, p_reg});
    assign m_s = $signed({1'b0, m_reg});

    always_comb
    begin
        case (quad_reg)
            obo_pkg::QUAD_0:
            begin
                sin_next = p_s;
                cos_next = m_s;
            end
            obo_pkg::QUAD_1:
            begin
                sin_next = m_s;
                cos_next = -p_s;
            end
            obo_pkg::QUAD_2:
            begin
                sin_next = -p_s;
                cos_next = -m_s;
            end
            default:
            begin
                sin_next = -m_s;
                cos_next = p_s;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

`default_nettype wire

FILE: rtl/obo_checker.sv
// Port-level checks for the overlap pipeline, bound to the top level.
`default_nettype none

module obo_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // a result offered but not taken stays offered with the same flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transaction dropped or changed while stalled");

    // fill bits above the flag are always zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("output padding not zero");

    // pipeline is empty right after reset release
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind oriented_box_overlap_sat obo_checker u_obo_checker (.*);

`default_nettype wire

FILE: bench/tb_oriented_box_overlap_sat.sv
// Self-checking testbench for the oriented box overlap (separating axis) pipeline.
`timescale 1ns / 100ps

module tb_oriented_box_overlap_sat;

    localparam int COORD_BITS = 16;
    localparam int ANGLE_BITS = 12;
    localparam int DATA_W = ((2*(4*COORD_BITS-2+ANGLE_BITS)+7)/8)*8;
    localparam int QSHIFT = ANGLE_BITS - 2;
    localparam longint QUARTER = 64'd1 << QSHIFT;
    localparam longint ONE_Q14 = 16384;
    localparam int RANDOM_PAIRS = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 30;

    // one box as it travels in s_tdata
    typedef struct packed {
        logic [ANGLE_BITS-1:0]   angle;
        logic [COORD_BITS-2:0]   height;
        logic [COORD_BITS-2:0]   width;
        logic [COORD_BITS-1:0]   cy;
        logic [COORD_BITS-1:0]   cx;
    } box_t;

    // box with its rotation resolved, Q1.14 sine/cosine
    typedef struct {
        longint cx, cy, w, h, s, c;
    } rot_box_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    // from bit 0: center_a_x, center_a_y, width_a, height_a, angle_a,
    // center_b_x, center_b_y, width_b, height_b, angle_b, zero fill
    logic [DATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    // bit 0: overlap, bits 7:1 zero
    logic [7:0] m_tdata;

    oriented_box_overlap_sat #(
        .COORD_BITS(COORD_BITS),
        .ANGLE_BITS(ANGLE_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    logic [DATA_W-1:0] pending_pairs[$];  // packed pairs not yet accepted
    logic              overlap_due[$];    // predicted flags, oldest first
    logic              in_fire;           // input transaction at the last rising edge
    logic              out_fire;          // output transaction at the last rising edge
    int                in_gap;
    int                out_stall;
    bit                in_burst;          // stretches with no input idling
    bit                out_burst;         // stretches with no output stall
    int                errors;
    int                cycles;
    int                hits;
    int                results;

    // ---------------------------------------------------------------
    // Predictor: quarter-wave sine as the ROM holds it, Q1.14
    // ---------------------------------------------------------------
    function automatic longint quarter_sine(longint unsigned t);
        longint unsigned r;
        longint unsigned r2;
        longint unsigned term;
        longint          sum;
        longint unsigned v;
        if (t > QUARTER)
            t = QUARTER;
        r = (t * 64'd1686629713 + (QUARTER >> 1)) >> QSHIFT;
        r2 = (r * r) >> 30;
        term = r;
        sum = longint'(r);
        for (int k = 1; k <= 6; k++)
        begin
            term = ((term * r2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (longint'(sum) + 32768) >> 16;
        if (v > ONE_Q14)
            v = ONE_Q14;
        return longint'(v);
    endfunction

    function automatic rot_box_t resolve_box(box_t b);
        rot_box_t rb;
        logic [1:0] quad;
        longint t, p, m;
        quad = b.angle[ANGLE_BITS-1 -: 2];
        t = longint'(b.angle[QSHIFT-1:0]);
        p = quarter_sine(t);
        m = quarter_sine(QUARTER - t);
        rb.cx = longint'($signed(b.cx));
        rb.cy = longint'($signed(b.cy));
        rb.w = longint'(b.width);
        rb.h = longint'(b.height);
        case (quad)
            obo_pkg::QUAD_0: begin rb.s = p;  rb.c = m;  end
            obo_pkg::QUAD_1: begin rb.s = m;  rb.c = -p; end
            obo_pkg::QUAD_2: begin rb.s = -p; rb.c = -m; end
            default:         begin rb.s = -m; rb.c = p;  end
        endcase
        return rb;
    endfunction

    // exact interval of the four corners on axis (ux, uy)
    function automatic void project_box(input rot_box_t b, input longint ux,
                                        input longint uy,
                                        output longint lo, output longint hi);
        longint dx, dy, px, py, d;
        lo = 0;
        hi = 0;
        for (int i = 0; i < 4; i++)
        begin
            dx = (i & 1) ? b.w : -b.w;
            dy = (i & 2) ? b.h : -b.h;
            px = b.cx * 32768 + (b.c * dx - b.s * dy);
            py = b.cy * 32768 + (b.s * dx + b.c * dy);
            d = ux * px + uy * py;
            if (i == 0 || d < lo)
                lo = d;
            if (i == 0 || d > hi)
                hi = d;
        end
    endfunction

    function automatic logic boxes_overlap(logic [DATA_W-1:0] pair);
        rot_box_t a, b;
        longint ax[6], ay[6];
        longint alo, ahi, blo, bhi;
        logic hit;
        a = resolve_box(pair[$bits(box_t)-1:0]);
        b = resolve_box(pair[2*$bits(box_t)-1:$bits(box_t)]);
        ax[0] = ONE_Q14; ay[0] = 0;
        ax[1] = 0;       ay[1] = ONE_Q14;
        ax[2] = a.c;     ay[2] = a.s;
        ax[3] = -a.s;    ay[3] = a.c;
        ax[4] = b.c;     ay[4] = b.s;
        ax[5] = -b.s;    ay[5] = b.c;
        hit = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            project_box(a, ax[i], ay[i], alo, ahi);
            project_box(b, ax[i], ay[i], blo, bhi);
            // closed intervals: touching still counts as overlap
            if (!(blo <= ahi && alo <= bhi))
                hit = 1'b0;
        end
        return hit;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic box_t make_box(int cx, int cy, int w, int h, int ang);
        box_t b;
        b.cx = cx[COORD_BITS-1:0];
        b.cy = cy[COORD_BITS-1:0];
        b.width = w[COORD_BITS-2:0];
        b.height = h[COORD_BITS-2:0];
        b.angle = ang[ANGLE_BITS-1:0];
        return b;
    endfunction

    task automatic queue_pair(input box_t a, input box_t b);
        logic [DATA_W-1:0] d;
        d = '0;
        d[2*$bits(box_t)-1:0] = {b, a};
        pending_pairs.push_back(d);
    endtask

    function automatic box_t random_box();
        box_t b;
        b.cx = COORD_BITS'($urandom);
        b.cy = COORD_BITS'($urandom);
        b.width = (COORD_BITS-1)'($urandom);
        b.height = (COORD_BITS-1)'($urandom);
        b.angle = ANGLE_BITS'($urandom);
        return b;
    endfunction

    task automatic report_mismatch(input logic [7:0] got, input logic want);
        errors++;
        $display("MISMATCH at cycle %0d: overlap flag got 0x%02h, expected 0x%02h",
                 cycles, got, {7'b0, want});
    endtask

    // ---------------------------------------------------------------
    // Clock and reset
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Rising edge: record transactions, predict on input, check on output
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
            out_fire <= 1'b0;
            cycles <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            in_fire <= s_tvalid && s_tready;
            out_fire <= m_tvalid && m_tready;
            if (s_tvalid && s_tready)
            begin
                overlap_due.push_back(boxes_overlap(s_tdata));
                void'(pending_pairs.pop_front());
            end
            if (m_tvalid && m_tready)
            begin
                results++;
                if (overlap_due.size() == 0)
                begin
                    errors++;
                    $display("MISMATCH at cycle %0d: result 0x%02h with none expected",
                             cycles, m_tdata);
                end
                else
                begin
                    logic want;
                    want = overlap_due.pop_front();
                    if (want)
                        hits++;
                    if (m_tdata !== {7'b0, want})
                        report_mismatch(m_tdata, want);
                end
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Falling edge: input driver with random gaps between transactions
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            in_gap <= 0;
        end
        else if (s_tvalid && !in_fire)
        begin
            // holding the current pair until it is taken
        end
        else
        begin
            int gap;
            gap = in_gap;
            if (in_fire)
            begin
                if ($urandom_range(0, 60) == 0)
                    in_burst = !in_burst;
                gap = in_burst ? 0 : $urandom_range(0, 13);
            end
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                in_gap <= gap - 1;
            end
            else if (pending_pairs.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_pairs[0];
                in_gap <= 0;
            end
            else
            begin
                s_tvalid <= 1'b0;
                in_gap <= 0;
            end
        end
    end

    // output side: stall drawn per result
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            out_stall <= 0;
        end
        else
        begin
            int stall;
            stall = out_stall;
            if (out_fire)
            begin
                if ($urandom_range(0, 60) == 0)
                    out_burst = !out_burst;
                stall = out_burst ? 0 : $urandom_range(0, 13);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                out_stall <= stall - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                out_stall <= 0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence: directed pairs, then random ones, then drain
    // ---------------------------------------------------------------
    initial
    begin
        int span, sz;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        errors = 0;
        hits = 0;
        results = 0;
        in_burst = 1'b0;
        out_burst = 1'b0;

        // two points at the origin: zero size on both boxes
        queue_pair(make_box(0, 0, 0, 0, 0), make_box(0, 0, 0, 0, 0));
        // point against a rotated zero-width segment, axes still follow the angle
        queue_pair(make_box(0, 0, 0, 0, 512), make_box(0, 0, 0, 160, 1365));
        // axis aligned boxes side by side with a gap, then one step further apart
        queue_pair(make_box(0, 0, 16, 16, 0), make_box(32, 0, 16, 16, 0));
        queue_pair(make_box(0, 0, 16, 16, 0), make_box(33, 0, 16, 16, 0));
        queue_pair(make_box(0, -32, 16, 16, 0), make_box(0, 0, 16, 16, 0));
        // quadrant boundaries and the last angle step
        queue_pair(make_box(0, 0, 400, 20, 1024), make_box(0, 300, 20, 20, 0));
        queue_pair(make_box(0, 0, 400, 20, 2048), make_box(380, 0, 30, 30, 3072));
        queue_pair(make_box(0, 0, 400, 20, 3072), make_box(0, -405, 10, 10, 4095));
        queue_pair(make_box(5, 5, 300, 100, 4095), make_box(-5, 5, 100, 300, 1));
        // diamond next to a square, separated along the x axis
        queue_pair(make_box(0, 0, 100, 100, 512), make_box(250, 0, 100, 100, 0));
        queue_pair(make_box(0, 0, 100, 100, 512), make_box(240, 0, 100, 100, 0));
        // coordinate and size extremes
        queue_pair(make_box(32767, 32767, 32767, 32767, 0),
                   make_box(-32768, -32768, 32767, 32767, 0));
        queue_pair(make_box(-32768, -32768, 0, 0, 4095),
                   make_box(32767, 32767, 0, 0, 2048));
        queue_pair(make_box(32767, -32768, 32767, 0, 1536),
                   make_box(-32768, 32767, 0, 32767, 2560));
        queue_pair(make_box(-32768, 0, 32767, 32767, 3584),
                   make_box(32767, 0, 32767, 32767, 512));
        queue_pair(make_box(0, 0, 32767, 32767, 0), make_box(0, 0, 0, 0, 4095));
        queue_pair(make_box(1, -1, 1, 1, 2047), make_box(-1, 1, 1, 1, 2049));

        // random pairs: mostly nearby boxes so both outcomes are common,
        // the rest fully random fields to exercise every bit
        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            box_t a, b;
            if ($urandom_range(0, 3) == 0)
            begin
                a = random_box();
                b = random_box();
            end
            else
            begin
                span = (1 << $urandom_range(4, 13));
                sz = (1 << $urandom_range(2, 13));
                a = make_box($urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
                             $urandom_range(0, sz), $urandom_range(0, sz),
                             $urandom_range(0, 4095));
                b = make_box(int'($signed(a.cx)) + $urandom_range(0, 2 * span) - span,
                             int'($signed(a.cy)) + $urandom_range(0, 2 * span) - span,
                             $urandom_range(0, sz), $urandom_range(0, sz),
                             $urandom_range(0, 4095));
            end
            queue_pair(a, b);
        end

        wait (rst_n === 1'b1);
        while (pending_pairs.size() > 0 || overlap_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d overlap results (%0d overlapping, %0d apart)",
                 results, hits, results - hits);
        $display("Directed edge, extreme and zero-size pairs plus random pairs under random stalls");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
